// ===== rtl/blcs_pkg.sv =====
// Shared types and constants for the bounded lexicographic combination stepper.
// Used by the weight memory, the sequencer, the top level, the checker and the testbench.
// No dependencies.
package blcs_pkg;

	localparam int WORD_W  = 32;
	localparam int SUM_W   = 38;
	localparam int IDX_W   = 5;
	localparam int LEN_W   = 6;
	localparam int DEPTH   = 32;
	localparam int CMD_W   = 2;

	// Register indexes on the configuration port.
	localparam logic [0:0] REG_THRESHOLD = 1'b0;
	localparam logic [0:0] REG_LENGTH    = 1'b1;

	typedef logic signed [WORD_W-1:0] weight_t;
	typedef logic signed [SUM_W-1:0]  sum_t;
	typedef logic [WORD_W-1:0]        bits_t;
	typedef logic [IDX_W-1:0]         idx_t;
	typedef logic [LEN_W-1:0]         len_t;

	typedef enum logic [CMD_W-1:0] {
		CMD_LOAD  = 2'd0,
		CMD_START = 2'd1,
		CMD_NEXT  = 2'd2
	} cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SUM,
		ST_SUM_END,
		ST_STEP_RD,
		ST_STEP_EX,
		ST_RESULT
	} state_t;

	typedef struct packed {
		weight_t threshold;
		len_t    len;
	} cfg_t;

	typedef struct packed {
		logic [CMD_W-1:0] cmd;
		idx_t             index;
		weight_t          weight;
		len_t             ones;
	} item_t;

	typedef struct packed {
		logic    we;
		idx_t    waddr;
		weight_t wdata;
		idx_t    raddr_a;
		idx_t    raddr_b;
	} mem_req_t;

	typedef struct packed {
		bits_t combination;
		logic  found;
	} res_t;

	function automatic sum_t sext_w(input weight_t v);
		return {{(SUM_W-WORD_W){v[WORD_W-1]}}, v};
	endfunction

endpackage

// ===== rtl/bounded_lex_combination_stepper_core.sv =====
// Top level of the bounded lexicographic combination stepper.
// Depends on blcs_pkg, blcs_wmem and blcs_ctrl.
//
// Usage: words arrive on the slave stream (s_tvalid/s_tready). s_tuser carries the
// command: load a weight, start a combination, or step to the next combination.
// A load word writes one signed Q16.16 weight into the table and gives no result.
// A start or next word gives exactly one result word on the master stream, with
// the combination in m_tdata and the found flag in m_tuser.
// A load is written into the table as it is accepted. A start goes to the result
// state and then to the output register once that is free. A next word first sums
// the weights of the current string below the top position (one table read per
// cycle) and then scans pairs from the top down, each pair in ST_STEP_RD (read
// two weights) and ST_STEP_EX (add and compare). The single weight memory has
// registered read ports.
// Reset clears the current string, sets threshold to zero and length to 32; the
// weight table holds no defined value until loaded.
// The output register lets the block accept and work on the next word while the
// previous result waits on m_tready; a further result waits inside the sequencer
// and s_tready stays low until the output register frees up. The user must write the
// configuration port (cfg_we, cfg_index, cfg_wdata) only while idle; not enforced.
module bounded_lex_combination_stepper_core #(
	parameter int MAX_LENGTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,   // weight_index[4:0], weight_value[36:5], ones_count[42:37]
	input  logic [1:0]  s_tuser,   // command[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // combination[31:0]
	output logic        m_tuser,   // found[0]
	input  logic        cfg_we,
	input  logic [0:0]  cfg_index,
	input  logic [31:0] cfg_wdata
);

	// The string never exceeds the 32-entry table.
	localparam int LEN_LIM = (MAX_LENGTH < blcs_pkg::DEPTH) ? MAX_LENGTH : blcs_pkg::DEPTH;

	blcs_pkg::weight_t  threshold_q;
	blcs_pkg::len_t     length_q;
	blcs_pkg::cfg_t     cfg;
	blcs_pkg::item_t    item;
	blcs_pkg::mem_req_t mem_req;
	blcs_pkg::weight_t  rd_a;
	blcs_pkg::weight_t  rd_b;
	blcs_pkg::res_t     res;
	logic               res_valid;
	logic               out_free;
	logic               m_tvalid_q;
	logic [31:0]        m_tdata_q;
	logic               m_tuser_q;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= '0;
			length_q    <= blcs_pkg::LEN_W'(32);
		end else if (cfg_we) begin
			unique case (cfg_index)
				blcs_pkg::REG_THRESHOLD: threshold_q <= cfg_wdata;
				blcs_pkg::REG_LENGTH:    length_q    <= cfg_wdata[blcs_pkg::LEN_W-1:0];
				default:                 threshold_q <= threshold_q;
			endcase
		end
	end

	// The sequencer sees the length already saturated to the usable size.
	assign cfg.threshold = threshold_q;
	assign cfg.len = (length_q > blcs_pkg::LEN_W'(LEN_LIM)) ?
	                 blcs_pkg::LEN_W'(LEN_LIM) : length_q;

	// Unpack the input word.
	assign item.cmd    = s_tuser;
	assign item.index  = s_tdata[4:0];
	assign item.weight = s_tdata[36:5];
	assign item.ones   = s_tdata[42:37];

	blcs_wmem u_wmem (
		.clk  (clk),
		.req  (mem_req),
		.rd_a (rd_a),
		.rd_b (rd_b)
	);

	blcs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (s_tvalid),
		.item      (item),
		.in_ready  (s_tready),
		.mem_req   (mem_req),
		.rd_a      (rd_a),
		.rd_b      (rd_b),
		.res_valid (res_valid),
		.res       (res),
		.res_take  (out_free)
	);

	// Output register: takes a new result whenever it is empty or being drained.
	assign out_free = !m_tvalid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (res_valid && out_free) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && out_free) begin
			m_tdata_q <= res.combination;
			m_tuser_q <= res.found;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

endmodule

// ===== rtl/blcs_wmem.sv =====
// Weight table: one write port and two registered read ports.
// Depends on blcs_pkg.
module blcs_wmem (
	input  logic               clk,
	input  blcs_pkg::mem_req_t req,
	output blcs_pkg::weight_t  rd_a,
	output blcs_pkg::weight_t  rd_b
);

	blcs_pkg::weight_t mem [blcs_pkg::DEPTH];
	blcs_pkg::weight_t rd_a_q;
	blcs_pkg::weight_t rd_b_q;

	// Writes happen only while the sequencer is idle, when read data is unused.
	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
		rd_a_q <= mem[req.raddr_a];
		rd_b_q <= mem[req.raddr_b];
	end

	assign rd_a = rd_a_q;
	assign rd_b = rd_b_q;

endmodule

// ===== rtl/blcs_ctrl.sv =====
// Sequencer and datapath: table loads, start, prefix sum and backward scan over the weight table.
// Depends on blcs_pkg; drives the request port of blcs_wmem.
module blcs_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  blcs_pkg::cfg_t     cfg,
	input  logic               in_valid,
	input  blcs_pkg::item_t    item,
	output logic               in_ready,
	output blcs_pkg::mem_req_t mem_req,
	input  blcs_pkg::weight_t  rd_a,
	input  blcs_pkg::weight_t  rd_b,
	output logic               res_valid,
	output blcs_pkg::res_t     res,
	input  logic               res_take
);

	blcs_pkg::state_t  state_q, state_d;
	blcs_pkg::bits_t   bits_q;
	blcs_pkg::idx_t    p_q;
	blcs_pkg::len_t    n_q;
	blcs_pkg::sum_t    q_q;
	blcs_pkg::sum_t    r_q;
	blcs_pkg::weight_t wj_q;
	logic              dv_q;
	logic              db_q;
	blcs_pkg::res_t    res_q;

	logic              accept;
	logic              short_len;
	logic              last_sum;
	blcs_pkg::len_t    len_m1;
	blcs_pkg::len_t    len_m2;
	blcs_pkg::len_t    ones_sat;
	blcs_pkg::bits_t   start_mask;
	blcs_pkg::idx_t    j_c;
	blcs_pkg::len_t    jp1_c;
	blcs_pkg::len_t    jn_c;
	logic              bit_i;
	logic              bit_j;
	logic              attempt;
	logic              keep;
	logic              jset;
	blcs_pkg::sum_t    cand;
	blcs_pkg::bits_t   oh_i;
	blcs_pkg::bits_t   oh_j;
	blcs_pkg::bits_t   moved;
	blcs_pkg::bits_t   tail;
	blcs_pkg::bits_t   after_try;
	blcs_pkg::bits_t   after_collect;

	assign accept    = in_valid && in_ready;
	assign short_len = (cfg.len < blcs_pkg::LEN_W'(2));
	assign len_m1    = cfg.len - blcs_pkg::LEN_W'(1);
	assign len_m2    = cfg.len - blcs_pkg::LEN_W'(2);
	assign last_sum  = ({1'b0, p_q} == len_m2);
	assign ones_sat  = (item.ones > cfg.len) ? cfg.len : item.ones;
	assign start_mask = ~({blcs_pkg::WORD_W{1'b1}} << ones_sat);

	// Scan step: i is p_q, j is i + 1. Positions above j are all zero here.
	assign j_c     = p_q + blcs_pkg::IDX_W'(1);
	assign jp1_c   = {1'b0, j_c} + blcs_pkg::LEN_W'(1);
	assign jn_c    = {1'b0, j_c} + n_q;
	assign bit_i   = bits_q[p_q];
	assign bit_j   = bits_q[j_c];
	assign attempt = bit_i && !bit_j;
	assign cand    = q_q - blcs_pkg::sext_w(rd_a) + blcs_pkg::sext_w(wj_q) + r_q;
	assign keep    = attempt && (cand < blcs_pkg::sext_w(cfg.threshold));
	assign jset    = attempt || bit_j;
	assign oh_i    = blcs_pkg::WORD_W'(1) << p_q;
	assign oh_j    = blcs_pkg::WORD_W'(1) << j_c;
	assign moved   = (bits_q & ~oh_i) | oh_j;
	assign tail    = (~({blcs_pkg::WORD_W{1'b1}} << n_q)) << jp1_c;
	assign after_try     = attempt ? moved : bits_q;
	assign after_collect = jset ? (after_try & ~oh_j) : after_try;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= blcs_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d         = state_q;
		in_ready        = 1'b0;
		res_valid       = 1'b0;
		mem_req.we      = 1'b0;
		mem_req.waddr   = item.index;
		mem_req.wdata   = item.weight;
		mem_req.raddr_a = p_q;
		mem_req.raddr_b = len_m1[blcs_pkg::IDX_W-1:0];
		unique case (state_q)
			blcs_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					unique case (item.cmd)
						blcs_pkg::CMD_LOAD: begin
							mem_req.we = 1'b1;
						end
						blcs_pkg::CMD_START: begin
							state_d = blcs_pkg::ST_RESULT;
						end
						blcs_pkg::CMD_NEXT: begin
							state_d = short_len ? blcs_pkg::ST_RESULT : blcs_pkg::ST_SUM;
						end
						default: begin
							state_d = blcs_pkg::ST_IDLE;
						end
					endcase
				end
			end
			blcs_pkg::ST_SUM: begin
				if (last_sum) begin
					state_d = blcs_pkg::ST_SUM_END;
				end
			end
			blcs_pkg::ST_SUM_END: begin
				state_d = blcs_pkg::ST_STEP_RD;
			end
			blcs_pkg::ST_STEP_RD: begin
				mem_req.raddr_b = jn_c[blcs_pkg::IDX_W-1:0];
				state_d = blcs_pkg::ST_STEP_EX;
			end
			blcs_pkg::ST_STEP_EX: begin
				if (keep || (p_q == '0)) begin
					state_d = blcs_pkg::ST_RESULT;
				end else begin
					state_d = blcs_pkg::ST_STEP_RD;
				end
			end
			blcs_pkg::ST_RESULT: begin
				res_valid = 1'b1;
				if (res_take) begin
					state_d = blcs_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = blcs_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bits_q <= '0;
			p_q    <= '0;
			n_q    <= '0;
			dv_q   <= 1'b0;
		end else begin
			unique case (state_q)
				blcs_pkg::ST_IDLE: begin
					if (accept && (item.cmd == blcs_pkg::CMD_START)) begin
						bits_q <= start_mask;
					end
					if (accept && (item.cmd == blcs_pkg::CMD_NEXT)) begin
						p_q  <= '0;
						n_q  <= '0;
						dv_q <= 1'b0;
					end
				end
				blcs_pkg::ST_SUM: begin
					dv_q <= 1'b1;
					if (!last_sum) begin
						p_q <= p_q + blcs_pkg::IDX_W'(1);
					end
				end
				blcs_pkg::ST_STEP_EX: begin
					if (keep) begin
						bits_q <= moved | tail;
					end else begin
						bits_q <= after_collect;
						n_q    <= n_q + blcs_pkg::LEN_W'(jset);
						p_q    <= p_q - blcs_pkg::IDX_W'(1);
					end
				end
				default: begin
					dv_q <= dv_q;
				end
			endcase
		end
	end

	// Sums and the result word carry no reset; they are loaded before use.
	always_ff @(posedge clk) begin
		unique case (state_q)
			blcs_pkg::ST_IDLE: begin
				q_q <= '0;
				r_q <= '0;
				if (item.cmd == blcs_pkg::CMD_START) begin
					res_q <= '{combination: start_mask, found: 1'b1};
				end else begin
					res_q <= '{combination: '0, found: 1'b0};
				end
			end
			blcs_pkg::ST_SUM: begin
				db_q <= bits_q[p_q];
				if (dv_q && db_q) begin
					q_q <= q_q + blcs_pkg::sext_w(rd_a);
				end
			end
			blcs_pkg::ST_SUM_END: begin
				if (db_q) begin
					q_q <= q_q + blcs_pkg::sext_w(rd_a);
				end
				wj_q <= rd_b;
			end
			blcs_pkg::ST_STEP_EX: begin
				if (keep) begin
					res_q <= '{combination: moved | tail, found: 1'b1};
				end else begin
					// Slide the collected-ones window down to start just after i.
					if (jset) begin
						r_q <= blcs_pkg::sext_w(wj_q) + r_q;
					end else begin
						r_q <= blcs_pkg::sext_w(wj_q) + r_q - blcs_pkg::sext_w(rd_b);
					end
					if (bit_i) begin
						q_q <= q_q - blcs_pkg::sext_w(rd_a);
					end
					wj_q  <= rd_a;
					res_q <= '{combination: '0, found: 1'b0};
				end
			end
			default: begin
				res_q <= res_q;
			end
		endcase
	end

	assign res = res_q;

endmodule

// ===== rtl/blcs_checker.sv =====
// Port-level checks for the combination stepper, bound to the top level.
// Depends on blcs_pkg and bounded_lex_combination_stepper_core.
module blcs_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [1:0]  s_tuser,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata,
	input logic        m_tuser
);

	// A stalled result word holds still.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result word changed while stalled");

	// An exhausted or short step reports an all-zero combination.
	a_not_found_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata == '0)
		else $error("combination not zero when found is low");

	// In the cycle after a start or next word is accepted, the block is busy.
	a_busy_after_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready &&
		(s_tuser == blcs_pkg::CMD_START || s_tuser == blcs_pkg::CMD_NEXT)
		|=> !s_tready)
		else $error("input accepted right after a start or next word");

	// A new result only leaves while the sequencer is busy handing it over.
	a_result_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> !$past(s_tready))
		else $error("result appeared without a pending command");

endmodule

bind bounded_lex_combination_stepper_core blcs_checker u_blcs_checker (.*);

// ===== test/tb_bounded_lex_combination_stepper_core.sv =====
// Self-checking testbench for bounded_lex_combination_stepper_core.
// Holds its own model of the weight table and the bit string and checks every
// result word; depends on blcs_pkg and the RTL of the core.
`timescale 1ns / 1ps

module tb_bounded_lex_combination_stepper_core;

	// The command encoding the block ignores; it has no member in the package enum.
	localparam logic [1:0] CMD_UNUSED    = 2'd3;

	localparam int MAX_LEN     = 32;
	// Covers the slowest next word plus a margin before a register write.
	localparam int SETTLE_CYC  = 3 * MAX_LEN + 40;
	localparam int MAX_GAP     = 18;
	localparam int RAND_PHASES = 10;
	localparam int PHASE_WORDS = 91;

	typedef struct packed {
		logic [1:0]        cmd;
		blcs_pkg::idx_t    index;
		blcs_pkg::weight_t weight;
		blcs_pkg::len_t    ones;
	} cmd_word_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [47:0] s_tdata   = '0;
	logic [1:0]  s_tuser   = '0;
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [31:0] m_tdata;
	logic        m_tuser;
	logic        cfg_we    = 1'b0;
	logic [0:0]  cfg_index = '0;
	logic [31:0] cfg_wdata = '0;

	bounded_lex_combination_stepper_core DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	// Shadow copy of the block state and its two registers.
	blcs_pkg::weight_t weight_shadow [blcs_pkg::DEPTH];
	blcs_pkg::bits_t   string_now;
	blcs_pkg::weight_t thr_now;
	blcs_pkg::len_t    len_now;

	cmd_word_t      cmd_words[$];       // words waiting for the driver
	blcs_pkg::res_t expected_combos[$]; // results owed by the block, oldest first
	cmd_word_t      word_on_bus;

	int  words_queued;
	int  words_taken;
	int  gap_left;
	int  stall_left;
	bit  tx_steady;
	bit  rx_steady;
	int  fail_count;
	int  results_checked;
	int  found_seen;
	int  exhausted_seen;
	int  settings_used;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// ---------------------------------------------------------------------
	// Prediction
	// ---------------------------------------------------------------------

	// Length register saturated to the positions the string really has.
	function automatic int eff_len();
		return (int'(len_now) > MAX_LEN) ? MAX_LEN : int'(len_now);
	endfunction

	// Steps string_now to the next combination whose weight sum stays below the
	// threshold. Pairs are scanned from the top down looking for a one with a zero
	// above it. Ones above a rejected pair are gathered and, when a move is taken,
	// packed right above the moved bit. Returns 1 when a move was taken; on
	// exhaustion the string keeps whatever the scan left in it.
	function automatic bit advance_string();
		int              span;
		int              i;
		int              j;
		int              gathered;
		blcs_pkg::bits_t s;
		longint          total;
		bit              done;
		bit              moved;
		span = eff_len();
		if (span < 2)
			return 1'b0;
		s        = string_now;
		gathered = 0;
		i        = span - 1;
		done     = 1'b0;
		moved    = 1'b0;
		while (!done) begin
			j = i;
			i = i - 1;
			if (s[i] && !s[j]) begin
				s[i]  = 1'b0;
				s[j]  = 1'b1;
				total = 0;
				for (int p = 0; p < span; p++)
					if (s[p])
						total += longint'(weight_shadow[p]);
				for (int k = 1; k <= gathered; k++)
					total += longint'(weight_shadow[j + k]);
				if (total < longint'(thr_now)) begin
					for (int k = 1; k <= gathered; k++)
						s[j + k] = 1'b1;
					moved = 1'b1;
					done  = 1'b1;
				end
			end
			if (!done) begin
				if (s[j]) begin
					gathered++;
					s[j] = 1'b0;
				end
				if (i == 0)
					done = 1'b1;
			end
		end
		string_now = s;
		return moved;
	endfunction

	// Applies one accepted word to the shadow state and tells whether it owes a
	// result, and which.
	function automatic void predict_combination(input cmd_word_t w, output bit gives,
			output blcs_pkg::res_t r);
		int ones;
		gives = 1'b0;
		r     = '0;
		case (w.cmd)
			blcs_pkg::CMD_LOAD: weight_shadow[w.index] = w.weight;
			blcs_pkg::CMD_START: begin
				ones = (int'(w.ones) > eff_len()) ? eff_len() : int'(w.ones);
				string_now = (ones >= 32) ? '1
					: ((blcs_pkg::bits_t'(1) << ones) - blcs_pkg::bits_t'(1));
				gives = 1'b1;
				r.combination = string_now;
				r.found = 1'b1;
			end
			blcs_pkg::CMD_NEXT: begin
				gives = 1'b1;
				if (advance_string()) begin
					r.combination = string_now;
					r.found = 1'b1;
				end
			end
			default: ;
		endcase
	endfunction

	// ---------------------------------------------------------------------
	// Driver: feeds the slave stream from cmd_words, with a random number of idle
	// cycles before each word. The prediction runs at the edge where a word is
	// accepted, so the shadow state sees words in exactly the block's order.
	// ---------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		bit             gives;
		blcs_pkg::res_t combo;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			gap_left  = 0;
		end else begin
			if (s_tvalid && s_tready) begin
				predict_combination(word_on_bus, gives, combo);
				if (gives)
					expected_combos.insert(expected_combos.size(), combo);
				words_taken++;
				gap_left = tx_steady ? 0 : $urandom_range(0, MAX_GAP);
			end
			// A word that is offered stays put until it is taken.
			if (!s_tvalid || s_tready) begin
				if (gap_left > 0) begin
					gap_left--;
					s_tvalid <= 1'b0;
				end else if (cmd_words.size() != 0) begin
					word_on_bus = cmd_words.pop_front();
					s_tvalid <= 1'b1;
					s_tdata  <= {5'd0, word_on_bus.ones, word_on_bus.weight, word_on_bus.index};
					s_tuser  <= word_on_bus.cmd;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// ---------------------------------------------------------------------
	// Monitor: drives m_tready with random stalls and checks each result word
	// against the oldest expectation.
	// ---------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		blcs_pkg::res_t want;
		int             stall;
		if (!arst_n) begin
			m_tready  <= 1'b0;
			stall_left = 0;
		end else if (m_tvalid && m_tready) begin
			results_checked++;
			if (m_tuser)
				found_seen++;
			else
				exhausted_seen++;
			if (expected_combos.size() == 0) begin
				$error("result word with nothing expected: combination %h found %b",
					m_tdata, m_tuser);
				fail_count++;
			end else begin
				want = expected_combos.pop_front();
				if (m_tdata !== want.combination) begin
					$error("combination: expected %h, got %h", want.combination, m_tdata);
					fail_count++;
				end
				if (m_tuser !== want.found) begin
					$error("found: expected %b, got %b", want.found, m_tuser);
					fail_count++;
				end
			end
			stall = rx_steady ? 0 : $urandom_range(0, MAX_GAP);
			if (stall == 0) begin
				m_tready <= 1'b1;
			end else begin
				m_tready  <= 1'b0;
				stall_left = stall - 1;
			end
		end else if (!m_tready) begin
			if (stall_left == 0)
				m_tready <= 1'b1;
			else
				stall_left--;
		end
	end

	// ---------------------------------------------------------------------
	// Stimulus helpers
	// ---------------------------------------------------------------------

	task automatic queue_word(input logic [1:0] cmd, input blcs_pkg::idx_t index,
			input blcs_pkg::weight_t w, input blcs_pkg::len_t ones);
		cmd_word_t c;
		c.cmd    = cmd;
		c.index  = index;
		c.weight = w;
		c.ones   = ones;
		cmd_words.insert(cmd_words.size(), c);
		words_queued++;
	endtask

	// Mostly modest Q16.16 values so that sums land on both sides of the
	// threshold, with the extremes and full-range values mixed in.
	function automatic blcs_pkg::weight_t rand_weight();
		case ($urandom_range(0, 9))
			0: return blcs_pkg::weight_t'(32'h8000_0000);
			1: return blcs_pkg::weight_t'(32'h7FFF_FFFF);
			2: return blcs_pkg::weight_t'($urandom);
			default: return blcs_pkg::weight_t'($urandom_range(0, 32'h0020_0000))
				- blcs_pkg::weight_t'(32'h0010_0000);
		endcase
	endfunction

	function automatic blcs_pkg::weight_t rand_threshold();
		case ($urandom_range(0, 9))
			0: return blcs_pkg::weight_t'(32'h8000_0000);
			1: return blcs_pkg::weight_t'(32'h7FFF_FFFF);
			2: return '0;
			default: return blcs_pkg::weight_t'($urandom_range(0, 32'h0100_0000))
				- blcs_pkg::weight_t'(32'h0080_0000);
		endcase
	endfunction

	// Random word with random don't-care fields, so every bit toggles.
	task automatic queue_random_word(input logic [1:0] cmd, input blcs_pkg::len_t ones);
		queue_word(cmd, blcs_pkg::idx_t'($urandom_range(0, 31)),
			blcs_pkg::weight_t'($urandom), ones);
	endtask

	// Waits until every word is taken and every result has come, then lets the
	// block finish any trailing load before the next register write.
	task automatic drain_block();
		while (words_taken != words_queued || expected_combos.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYC) @(posedge clk);
	endtask

	task automatic write_reg(input logic [0:0] index, input logic [31:0] value);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= index;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (index == blcs_pkg::REG_THRESHOLD)
			thr_now = blcs_pkg::weight_t'(value);
		else
			len_now = blcs_pkg::len_t'(value[blcs_pkg::LEN_W-1:0]);
	endtask

	task automatic set_regs(input blcs_pkg::weight_t thr, input blcs_pkg::len_t len);
		write_reg(blcs_pkg::REG_THRESHOLD, thr);
		write_reg(blcs_pkg::REG_LENGTH, 32'(len));
		settings_used++;
	endtask

	// Mostly well-formed runs: a start followed by a string of next words, with
	// some stray loads, ignored commands and next words with no fresh start.
	task automatic queue_random_phase(input int budget);
		int made;
		int pick;
		int run;
		int ones;
		made = 0;
		while (made < budget) begin
			pick = $urandom_range(0, 99);
			if (pick < 4) begin
				queue_random_word(CMD_UNUSED, blcs_pkg::len_t'($urandom_range(0, 63)));
			end else if (pick < 12) begin
				queue_word(blcs_pkg::CMD_LOAD, blcs_pkg::idx_t'($urandom_range(0, 31)),
					rand_weight(), blcs_pkg::len_t'($urandom_range(0, 63)));
				made++;
			end else if (pick < 16) begin
				queue_random_word(blcs_pkg::CMD_NEXT, blcs_pkg::len_t'($urandom_range(0, 63)));
				made++;
			end else begin
				ones = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 63)
					: $urandom_range(0, eff_len());
				queue_random_word(blcs_pkg::CMD_START, blcs_pkg::len_t'(ones));
				made++;
				run = $urandom_range(1, 24);
				for (int k = 0; k < run; k++) begin
					queue_random_word(blcs_pkg::CMD_NEXT,
						blcs_pkg::len_t'($urandom_range(0, 63)));
					made++;
				end
			end
		end
	endtask

	// ---------------------------------------------------------------------
	// Run
	// ---------------------------------------------------------------------
	initial begin
		blcs_pkg::len_t lens [12];
		arst_n     = 1'b0;
		string_now = '0;
		thr_now    = '0;
		len_now    = blcs_pkg::len_t'(MAX_LEN);
		lens = '{6'd2, 6'd3, 6'd4, 6'd5, 6'd6, 6'd8, 6'd12, 6'd16, 6'd24, 6'd32, 6'd33, 6'd63};
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Reset values: threshold zero and length 32. A next on the cleared string
		// finds no pair and reports exhaustion.
		queue_random_word(blcs_pkg::CMD_NEXT, 6'd0);
		queue_random_word(CMD_UNUSED, 6'd63);
		// Every weight is loaded before the first start.
		queue_word(blcs_pkg::CMD_LOAD, 5'd0, blcs_pkg::weight_t'(32'h7FFF_FFFF), 6'd63);
		queue_word(blcs_pkg::CMD_LOAD, 5'd1, blcs_pkg::weight_t'(32'h8000_0000), 6'd0);
		queue_word(blcs_pkg::CMD_LOAD, 5'd2, '0, 6'd21);
		queue_word(blcs_pkg::CMD_LOAD, 5'd3, blcs_pkg::weight_t'(32'hFFFF_FFFF), 6'd42);
		for (int p = 4; p < blcs_pkg::DEPTH; p++)
			queue_word(blcs_pkg::CMD_LOAD, blcs_pkg::idx_t'(p), rand_weight(),
				blcs_pkg::len_t'($urandom_range(0, 63)));
		// A start with too many ones is clipped to the length; the next word then
		// scans down from a full string.
		queue_random_word(blcs_pkg::CMD_START, 6'd40);
		queue_random_word(blcs_pkg::CMD_NEXT, 6'd0);
		queue_random_word(blcs_pkg::CMD_START, 6'd3);
		repeat (3) queue_random_word(blcs_pkg::CMD_NEXT, 6'd0);
		queue_random_word(blcs_pkg::CMD_START, 6'd0);
		queue_random_word(blcs_pkg::CMD_NEXT, 6'd0);
		drain_block();

		// Highest threshold and a length register beyond the string size.
		set_regs(blcs_pkg::weight_t'(32'h7FFF_FFFF), 6'd63);
		queue_random_word(blcs_pkg::CMD_START, 6'd31);
		repeat (3) queue_random_word(blcs_pkg::CMD_NEXT, 6'd0);
		drain_block();

		// Short strings: length zero and one never step.
		set_regs('0, 6'd0);
		queue_random_word(blcs_pkg::CMD_START, 6'd5);
		queue_random_word(blcs_pkg::CMD_NEXT, 6'd0);
		drain_block();
		set_regs(blcs_pkg::weight_t'(32'h0001_0000), 6'd1);
		queue_random_word(blcs_pkg::CMD_START, 6'd1);
		queue_random_word(blcs_pkg::CMD_NEXT, 6'd0);
		drain_block();

		// Lowest threshold over the extreme weights: the sums must be exact well
		// past 32 bits for the compare to come out right.
		set_regs(blcs_pkg::weight_t'(32'h8000_0000), 6'd4);
		queue_random_word(blcs_pkg::CMD_START, 6'd2);
		repeat (3) queue_random_word(blcs_pkg::CMD_NEXT, 6'd0);
		drain_block();

		// Random phases, each with its own threshold and length. One phase runs
		// both sides with no idle cycles at all; another only the receiver.
		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			tx_steady = (ph == 3);
			rx_steady = (ph == 3 || ph == 6);
			set_regs(rand_threshold(),
				(ph % 3 == 2) ? blcs_pkg::len_t'($urandom_range(0, 63))
				: lens[$urandom_range(0, 11)]);
			queue_random_phase(PHASE_WORDS);
			drain_block();
		end

		$display("summary: %0d words sent over %0d register settings, %0d results checked",
			words_taken, settings_used, results_checked);
		$display("summary: %0d combinations found, %0d exhausted or short-string answers",
			found_seen, exhausted_seen);
		if (fail_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	// Watchdog, several times the slowest legal run.
	initial begin
		#4_000_000;
		$display("tb: failure");
		$finish;
	end

endmodule
